// ===== src/packed_pixel_store_engine_macros.svh =====
// ---------------------------------------------------------------------------
// Packed pixel store engine assertion macros
// Shorthand for the concurrent checks of the top level. The checks use the
// clock i_clk and the active-low reset i_rst_n of the including module.
// ---------------------------------------------------------------------------
`ifndef PACKED_PIXEL_STORE_ENGINE_MACROS_SVH
`define PACKED_PIXEL_STORE_ENGINE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/pps_pkg.sv =====
// ---------------------------------------------------------------------------
// Packed pixel store package
// Sizes, codes, shared types and address helper functions of the engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pps_pkg;

    // Frame store size in bytes and the largest bitmap side in pixels.
    localparam int MEM_BYTES = 65536;
    localparam int MAX_DIM   = 1024;

    localparam int MEM_AW  = $clog2(MEM_BYTES);
    localparam int DIM_W   = $clog2(MAX_DIM);
    localparam int EDIM_W  = $clog2(MAX_DIM + 1);
    localparam int PITCH_W = $clog2(MAX_DIM + 4);
    localparam int ROW_W   = DIM_W + PITCH_W;
    localparam int ADDR_W  = (ROW_W + 1 > MEM_AW + 1) ? ROW_W + 1 : MEM_AW + 1;

    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_CODE   = 2'd2;

    // Opcodes of an input transaction.
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_FILL  = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Work classes handed from the front to the back.
    typedef enum logic [1:0] {
        K_READ,
        K_WRITE,
        K_FILL,
        K_REPLY
    } t_kind;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_ROW,
        B_READ,
        B_WRITE,
        B_HOLD
    } t_bstate;

    typedef struct packed {
        logic [CFG_W-1:0] frame_width;
        logic [CFG_W-1:0] frame_height;
        logic [1:0]       depth_code;
    } t_cfg;

    typedef struct packed {
        t_kind            kind;
        logic [DIM_W-1:0] x0;
        logic [DIM_W-1:0] y0;
        logic [DIM_W-1:0] x1;
        logic [DIM_W-1:0] y1;
        logic [7:0]       color;
        logic [1:0]       status;
    } t_cmd;

    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_qreq;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_qhead;

    // Register value limited to the largest supported side.
    function automatic logic [EDIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
        if (32'(v) > MAX_DIM) begin
            return EDIM_W'(MAX_DIM);
        end
        return EDIM_W'(v);
    endfunction

    // Bytes per row: bits rounded up to a whole 32-bit word.
    function automatic logic [PITCH_W-1:0] row_pitch(input logic [EDIM_W-1:0] ew,
                                                    input logic [1:0] dc);
        logic [EDIM_W+4:0] bits;
        bits = ((EDIM_W+5)'(ew) << dc) + (EDIM_W+5)'(31);
        return PITCH_W'(bits >> 3) & ~PITCH_W'(3);
    endfunction

    function automatic logic [7:0] depth_mask(input logic [1:0] dc);
        logic [7:0] m;
        unique case (dc)
            2'd0: m = 8'h01;
            2'd1: m = 8'h03;
            2'd2: m = 8'h0F;
            default: m = 8'hFF;
        endcase
        return m;
    endfunction

endpackage

// ===== src/pps_in_if.sv =====
// ---------------------------------------------------------------------------
// Pixel request channel
// Valid/ready channel that carries one pixel or rectangle request.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pps_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic signed [15:0] x_end;
    logic signed [15:0] y_end;
    logic [7:0]        color;

    modport source (output valid, opcode, x_pos, y_pos, x_end, y_end, color,
                    input ready);
    modport sink (input valid, opcode, x_pos, y_pos, x_end, y_end, color,
                  output ready);
endinterface

// ===== src/pps_out_if.sv =====
// ---------------------------------------------------------------------------
// Pixel result channel
// Valid/ready channel that carries one result per request.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pps_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_value;
    logic [1:0] status;

    modport source (output valid, pixel_value, status, input ready);
    modport sink (input valid, pixel_value, status, output ready);
endinterface

// ===== src/packed_pixel_store_engine.sv =====
// ---------------------------------------------------------------------------
// Packed pixel store engine: requests wait in a queue; a pixel read or write
// takes a read state then a write state on its byte, as the store's read data
// is registered, and a fill does so per covered pixel, row by row with a row
// state between rows, skipping bytes beyond the store. One rejected request per
// cycle while the result channel is ready. Synchronous reset, then a full clear.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "packed_pixel_store_engine_macros.svh"

module packed_pixel_store_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pps_pkg::CFG_W-1:0]     i_cfg_data,
    pps_in_if.sink                        i_pix,
    pps_out_if.source                     o_res
);

    logic [pps_pkg::CFG_W-1:0] r_frame_width, r_frame_height;
    logic [1:0]                r_depth_code;
    pps_pkg::t_cfg             cfg;
    pps_pkg::t_qreq            req;
    pps_pkg::t_qhead           head;
    logic                      q_full, pop, clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= '0;
            r_frame_height <= '0;
            r_depth_code   <= 2'd3;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pps_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                pps_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                pps_pkg::CFG_DEPTH_CODE:   r_depth_code   <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg.frame_width  = r_frame_width;
    assign cfg.frame_height = r_frame_height;
    assign cfg.depth_code   = r_depth_code;

    pps_front u_front (
        .i_cfg   (cfg),
        .i_enable(!clearing),
        .i_full  (q_full),
        .i_pix   (i_pix),
        .o_req   (req)
    );

    pps_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req),
        .o_full (q_full),
        .i_pop  (pop),
        .o_head (head)
    );

    pps_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_head    (head),
        .o_pop     (pop),
        .o_clearing(clearing),
        .o_res     (o_res)
    );

    `PPS_ASSERT_IMPLY(a_no_accept_clear, clearing, !i_pix.ready, "request taken during clear")
    `PPS_ASSERT_IMPLY(a_no_push_full, q_full, !req.push, "command pushed into a full queue")
    `PPS_ASSERT_IMPLY(a_pop_has_head, pop, head.valid, "command popped from an empty queue")
    `PPS_ASSERT_NEXT(a_clear_blocks_back, clearing, !pop, "command run before clear finished")

endmodule

// ===== src/pps_ram.sv =====
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== src/pps_front.sv =====
// ---------------------------------------------------------------------------
// Packed pixel store front end
// Accepts requests, checks them against the bitmap and clips rectangles.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pps_front (
    input  pps_pkg::t_cfg i_cfg,
    input  logic          i_enable,
    input  logic          i_full,
    pps_in_if.sink        i_pix,
    output pps_pkg::t_qreq o_req
);

    localparam int CW = ((pps_pkg::EDIM_W > 16) ? pps_pkg::EDIM_W : 16) + 1;

    logic signed [CW-1:0] w_s, h_s;
    logic signed [CW-1:0] x_s, y_s, xe_s, ye_s;
    logic signed [CW-1:0] cx0, cy0, cx1, cy1;
    logic                 in_bitmap, reversed, empty;

    assign i_pix.ready = i_enable && !i_full;

    always_comb begin
        w_s  = $signed(CW'(pps_pkg::eff_dim(i_cfg.frame_width)));
        h_s  = $signed(CW'(pps_pkg::eff_dim(i_cfg.frame_height)));
        x_s  = CW'(i_pix.x_pos);
        y_s  = CW'(i_pix.y_pos);
        xe_s = CW'(i_pix.x_end);
        ye_s = CW'(i_pix.y_end);

        in_bitmap = (x_s >= 0) && (y_s >= 0) && (x_s < w_s) && (y_s < h_s);
        reversed  = (x_s > xe_s) || (y_s > ye_s);

        cx0 = (x_s < 0) ? '0 : x_s;
        cy0 = (y_s < 0) ? '0 : y_s;
        cx1 = (xe_s >= w_s) ? w_s - CW'(1) : xe_s;
        cy1 = (ye_s >= h_s) ? h_s - CW'(1) : ye_s;
        empty = (cx0 > cx1) || (cy0 > cy1);

        o_req.push       = i_pix.valid && i_pix.ready;
        o_req.cmd.color  = i_pix.color;
        o_req.cmd.status = pps_pkg::ST_RANGE;
        o_req.cmd.kind   = pps_pkg::K_REPLY;
        o_req.cmd.x0     = pps_pkg::DIM_W'(x_s);
        o_req.cmd.y0     = pps_pkg::DIM_W'(y_s);
        o_req.cmd.x1     = pps_pkg::DIM_W'(x_s);
        o_req.cmd.y1     = pps_pkg::DIM_W'(y_s);

        priority if (i_pix.opcode == pps_pkg::OP_FILL) begin
            if (reversed || empty) begin
                o_req.cmd.status = pps_pkg::ST_EMPTY;
            end else begin
                o_req.cmd.kind = pps_pkg::K_FILL;
                o_req.cmd.x0   = pps_pkg::DIM_W'(cx0);
                o_req.cmd.y0   = pps_pkg::DIM_W'(cy0);
                o_req.cmd.x1   = pps_pkg::DIM_W'(cx1);
                o_req.cmd.y1   = pps_pkg::DIM_W'(cy1);
            end
        end else if (i_pix.opcode == pps_pkg::OP_READ && in_bitmap) begin
            o_req.cmd.kind = pps_pkg::K_READ;
        end else if (i_pix.opcode == pps_pkg::OP_WRITE && in_bitmap) begin
            o_req.cmd.kind = pps_pkg::K_WRITE;
        end else begin
            // Pixel off the bitmap or an unused opcode: answered at once.
            o_req.cmd.kind = pps_pkg::K_REPLY;
        end
    end

endmodule

// ===== src/pps_queue.sv =====
// ---------------------------------------------------------------------------
// Packed pixel store command queue
// Short FIFO of classified commands between the front and the back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pps_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pps_pkg::t_qreq i_req,
    output logic           o_full,
    input  logic           i_pop,
    output pps_pkg::t_qhead o_head
);

    pps_pkg::t_cmd                   r_mem [pps_pkg::QUEUE_DEPTH];
    logic [pps_pkg::QPTR_W-1:0]      r_wptr, r_rptr;
    logic [pps_pkg::QCNT_W-1:0]      r_count;

    function automatic logic [pps_pkg::QPTR_W-1:0] bump(
        input logic [pps_pkg::QPTR_W-1:0] p);
        if (32'(p) == pps_pkg::QUEUE_DEPTH - 1) begin
            return '0;
        end
        return p + pps_pkg::QPTR_W'(1);
    endfunction

    assign o_full      = (32'(r_count) == pps_pkg::QUEUE_DEPTH);
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_req.push) begin
                r_wptr <= bump(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= bump(r_rptr);
            end
            if (i_req.push && !i_pop) begin
                r_count <= r_count + pps_pkg::QCNT_W'(1);
            end else if (!i_req.push && i_pop) begin
                r_count <= r_count - pps_pkg::QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.push) begin
            r_mem[r_wptr] <= i_req.cmd;
        end
    end

endmodule

// ===== src/pps_back.sv =====
// ---------------------------------------------------------------------------
// Packed pixel store back end
// Clears the frame store, then runs each command as byte reads, with a write
// back for writes and fills, and places the result in the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pps_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pps_pkg::t_cfg   i_cfg,
    input  pps_pkg::t_qhead i_head,
    output logic            o_pop,
    output logic            o_clearing,
    pps_out_if.source       o_res
);

    localparam logic [pps_pkg::MEM_AW-1:0] CLR_LAST =
        pps_pkg::MEM_AW'(pps_pkg::MEM_BYTES - 1);

    pps_pkg::t_bstate r_state, n_state;
    pps_pkg::t_cmd    r_cmd;

    logic [pps_pkg::DIM_W-1:0]   r_x, r_y, mul_y, xoff;
    logic                        r_skip;
    logic [pps_pkg::ROW_W-1:0]   r_row, product;
    logic [pps_pkg::MEM_AW-1:0]  r_addr, r_clr_addr;
    logic [pps_pkg::PITCH_W-1:0] pitch;
    logic [pps_pkg::ADDR_W-1:0]  addr_full;
    logic                        in_mem, last_x, last_y, out_free, is_reply;
    logic [2:0]                  shift;
    logic [7:0]                  mask, rdata, new_byte, extract;

    logic [7:0] r_res_value, r_out_value, res_value;
    logic [1:0] r_res_status, r_out_status, res_status;
    logic       r_out_valid;

    logic                       ram_we;
    logic [pps_pkg::MEM_AW-1:0] ram_waddr;
    logic [7:0]                 ram_wdata;
    logic                       fin, step, skip_now, emit_hold, emit_reply;

    pps_ram #(
        .WIDTH(8),
        .DEPTH(pps_pkg::MEM_BYTES)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(addr_full[pps_pkg::MEM_AW-1:0]),
        .o_rdata(rdata)
    );

    // Address arithmetic. The row product is registered once per row.
    always_comb begin
        pitch = pps_pkg::row_pitch(pps_pkg::eff_dim(i_cfg.frame_width), i_cfg.depth_code);
        mul_y = (r_state == pps_pkg::B_IDLE) ? i_head.cmd.y0 : r_y;
        product = pps_pkg::ROW_W'(mul_y) * pps_pkg::ROW_W'(pitch);
        xoff = r_x >> (2'd3 - i_cfg.depth_code);
        addr_full = pps_pkg::ADDR_W'(r_row) + pps_pkg::ADDR_W'(xoff);
        in_mem = addr_full < pps_pkg::ADDR_W'(pps_pkg::MEM_BYTES);
        // The leftmost pixel of a byte sits in its most significant bits.
        shift = 3'((~r_x[2:0] & (3'b111 >> i_cfg.depth_code)) << i_cfg.depth_code);
        mask = pps_pkg::depth_mask(i_cfg.depth_code);
        new_byte = (rdata & ~(mask << shift)) | ((r_cmd.color & mask) << shift);
        extract = (rdata >> shift) & mask;
        last_x = (r_x == r_cmd.x1);
        last_y = (r_y == r_cmd.y1);
        out_free = !r_out_valid || o_res.ready;
        is_reply = (i_head.cmd.kind == pps_pkg::K_REPLY);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pps_pkg::B_CLEAR: begin
                if (r_clr_addr == CLR_LAST) begin
                    n_state = pps_pkg::B_IDLE;
                end
            end
            pps_pkg::B_IDLE: begin
                if (i_head.valid && !is_reply) begin
                    n_state = pps_pkg::B_READ;
                end
            end
            pps_pkg::B_ROW: begin
                n_state = pps_pkg::B_READ;
            end
            pps_pkg::B_READ: begin
                if (in_mem) begin
                    n_state = pps_pkg::B_WRITE;
                end else if (last_x && last_y) begin
                    n_state = out_free ? pps_pkg::B_IDLE : pps_pkg::B_HOLD;
                end else if (last_x) begin
                    n_state = pps_pkg::B_ROW;
                end
            end
            pps_pkg::B_WRITE: begin
                if (last_x && last_y) begin
                    n_state = out_free ? pps_pkg::B_IDLE : pps_pkg::B_HOLD;
                end else if (last_x) begin
                    n_state = pps_pkg::B_ROW;
                end else begin
                    n_state = pps_pkg::B_READ;
                end
            end
            pps_pkg::B_HOLD: begin
                if (out_free) begin
                    n_state = pps_pkg::B_IDLE;
                end
            end
            default: n_state = pps_pkg::B_CLEAR;
        endcase
    end

    always_comb begin
        o_pop      = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = r_addr;
        ram_wdata  = new_byte;
        fin        = 1'b0;
        step       = 1'b0;
        skip_now   = 1'b0;
        emit_hold  = 1'b0;
        emit_reply = 1'b0;
        unique case (r_state)
            pps_pkg::B_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
            end
            pps_pkg::B_IDLE: begin
                o_pop      = i_head.valid && (!is_reply || out_free);
                emit_reply = i_head.valid && is_reply && out_free;
            end
            pps_pkg::B_READ: begin
                // A byte beyond the store is skipped and marks the result.
                if (!in_mem) begin
                    skip_now = 1'b1;
                    step     = 1'b1;
                    fin      = last_x && last_y;
                end
            end
            pps_pkg::B_WRITE: begin
                step   = 1'b1;
                fin    = last_x && last_y;
                ram_we = (r_cmd.kind != pps_pkg::K_READ);
            end
            pps_pkg::B_HOLD: begin
                emit_hold = out_free;
            end
            default: begin
            end
        endcase

        res_status = (r_skip || skip_now) ? pps_pkg::ST_RANGE : pps_pkg::ST_OK;
        priority if (r_cmd.kind == pps_pkg::K_READ && r_state == pps_pkg::B_WRITE) begin
            res_value = extract;
        end else if (r_cmd.kind == pps_pkg::K_WRITE && !skip_now) begin
            res_value = r_cmd.color;
        end else begin
            res_value = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pps_pkg::B_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == pps_pkg::B_CLEAR) begin
                r_clr_addr <= r_clr_addr + pps_pkg::MEM_AW'(1);
            end
            if ((fin && out_free) || emit_hold || emit_reply) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && !is_reply) begin
            r_cmd  <= i_head.cmd;
            r_x    <= i_head.cmd.x0;
            r_y    <= i_head.cmd.y0;
            r_skip <= 1'b0;
        end
        if (r_state == pps_pkg::B_IDLE || r_state == pps_pkg::B_ROW) begin
            r_row <= product;
        end
        if (r_state == pps_pkg::B_READ && in_mem) begin
            r_addr <= addr_full[pps_pkg::MEM_AW-1:0];
        end
        if (skip_now) begin
            r_skip <= 1'b1;
        end
        if (step) begin
            if (!last_x) begin
                r_x <= r_x + pps_pkg::DIM_W'(1);
            end else if (!last_y) begin
                r_x <= r_cmd.x0;
                r_y <= r_y + pps_pkg::DIM_W'(1);
            end
        end
        if (fin && !out_free) begin
            r_res_value  <= res_value;
            r_res_status <= res_status;
        end
        if (fin && out_free) begin
            r_out_value  <= res_value;
            r_out_status <= res_status;
        end else if (emit_hold) begin
            r_out_value  <= r_res_value;
            r_out_status <= r_res_status;
        end else if (emit_reply) begin
            r_out_value  <= '0;
            r_out_status <= i_head.cmd.status;
        end
    end

    assign o_clearing        = (r_state == pps_pkg::B_CLEAR);
    assign o_res.valid       = r_out_valid;
    assign o_res.pixel_value = r_out_value;
    assign o_res.status      = r_out_status;

endmodule
